[src/trd_pkg.sv]
// Package for the TGA run-length pixel decoder: shared types and constants.
// Used by trd_ctrl, trd_datapath and tga_rle_pixel_decoder_top; no dependencies.
package trd_pkg;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_PER_PIXEL = 1'b0,
    CFG_IMAGE_WIDTH     = 1'b1
  } cfg_reg_t;

  localparam logic [2:0]  BPP_RESET   = 3'd3;
  localparam logic [15:0] WIDTH_RESET = 16'd256;
  localparam logic [15:0] MIN_WIDTH   = 16'd4;
  localparam logic [15:0] LINE_MAX    = 16'hFFFF;
  localparam logic [7:0]  RUN_BIAS    = 8'd127;
  localparam int          MAX_PIXEL_BYTES_DEF = 4;

  // Decoder phase.
  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_LITERAL = 2'd1,
    ST_RUN     = 2'd2,
    ST_SPAN    = 2'd3
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic hdr_load;   // latch pixel count from a header beat
    logic pix_byte;   // merge a pixel byte into the accumulator
    logic emit;       // load one span into the output register
    logic use_rem;    // span continues a run: remaining count and held color
    logic is_run;     // first span of a run: count is the packet count
    logic lit_dec;    // one literal pixel consumed
    logic hold_color; // keep the run color for later spans
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_literal; // header beat announces literal pixels
    logic pix_done;    // the current pixel byte completes a pixel
    logic span_done;   // the span being computed is the last of its pixel or run
    logic lit_end;     // the literal pixel being finished is the packet's last
    logic slot_free;   // the output register can take a span this cycle
  } stat_t;

endpackage

[src/tga_rle_pixel_decoder_top.sv]
// Top level of the TGA run-length pixel decoder.
// Instantiates trd_ctrl and trd_datapath; depends on trd_pkg.
//
// Usage: the input channel takes one stream byte per beat (in_valid,
// in_stall, in_data_byte). The result channel delivers one span per beat
// (out_valid, out_stall, color, line, start column, length and a last flag
// that marks the final span caused by one input byte). Header beats and pixel
// bytes that do not finish a pixel produce no span.
// A span is loaded into the output register in the cycle after the byte
// that completes its pixel is accepted. Throughput: one byte per cycle while
// the output keeps draining. A run that crosses k line ends yields k+1 spans,
// emitted one per cycle from the span splitter while the output drains; the
// input is held stalled until the last of those spans is emitted.
// When the receiver stalls, the pending span holds and every pixel byte is
// stalled until the span is taken; header bytes are still taken.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle. Synchronous reset (rst_n low) returns to header parsing at
// line 0, column 0, 3 bytes per pixel and 256 pixels per line; there is no
// clearing pass, the block is ready in the first cycle after reset.
module tga_rle_pixel_decoder_top #(
  parameter int MAX_PIXEL_BYTES = trd_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_color,
  output logic [15:0]                    out_line,
  output logic [15:0]                    out_start_column,
  output logic [7:0]                     out_span_length,
  output logic                           out_last
);

  // Command and status buses between the controller and the datapath.
  trd_pkg::cmd_t  cmd;
  trd_pkg::stat_t stat;

  // The controller tracks the packet phase and decides, beat by beat, when
  // the datapath merges a byte, emits a span or continues a split run.
  trd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the pixel accumulator, the line
  // and column position and the output register.
  trd_datapath #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_data_byte     (in_data_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_color        (out_color),
    .out_line         (out_line),
    .out_start_column (out_start_column),
    .out_span_length  (out_span_length),
    .out_last         (out_last)
  );

endmodule

[src/trd_ctrl.sv]
// Controller state machine of the TGA run-length pixel decoder.
// Depends on trd_pkg for the state, command and status types.
module trd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  trd_pkg::stat_t stat,
  output trd_pkg::cmd_t  cmd
);

  trd_pkg::state_t state_r, state_nxt;
  logic fire;

  assign fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trd_pkg::ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      trd_pkg::ST_HEADER: begin
        if (fire) begin
          state_nxt = stat.hdr_literal ? trd_pkg::ST_LITERAL : trd_pkg::ST_RUN;
        end
      end
      trd_pkg::ST_LITERAL: begin
        if (fire && stat.pix_done && stat.lit_end) begin
          state_nxt = trd_pkg::ST_HEADER;
        end
      end
      trd_pkg::ST_RUN: begin
        if (fire && stat.pix_done) begin
          state_nxt = stat.span_done ? trd_pkg::ST_HEADER : trd_pkg::ST_SPAN;
        end
      end
      trd_pkg::ST_SPAN: begin
        if (stat.slot_free && stat.span_done) begin
          state_nxt = trd_pkg::ST_HEADER;
        end
      end
      default: begin
        state_nxt = trd_pkg::ST_HEADER;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b0;
    unique case (state_r)
      trd_pkg::ST_HEADER: begin
        cmd.hdr_load = fire;
      end
      trd_pkg::ST_LITERAL: begin
        in_stall    = !stat.slot_free;
        cmd.pix_byte = fire;
        cmd.emit     = fire && stat.pix_done;
        cmd.lit_dec  = fire && stat.pix_done;
      end
      trd_pkg::ST_RUN: begin
        in_stall       = !stat.slot_free;
        cmd.pix_byte   = fire;
        cmd.is_run     = 1'b1;
        cmd.emit       = fire && stat.pix_done;
        cmd.hold_color = fire && stat.pix_done;
      end
      trd_pkg::ST_SPAN: begin
        in_stall    = 1'b1;
        cmd.use_rem = 1'b1;
        cmd.emit    = stat.slot_free;
      end
      default: begin
        cmd.hdr_load = fire;
      end
    endcase
  end

endmodule

[src/trd_datapath.sv]
// Datapath of the TGA run-length pixel decoder: configuration, pixel assembly,
// span splitting and the output register. Depends on trd_pkg.
module trd_datapath #(
  parameter int MAX_PIXEL_BYTES = trd_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                    in_data_byte,
  input  trd_pkg::cmd_t                 cmd,
  output trd_pkg::stat_t                stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_color,
  output logic [15:0]                   out_line,
  output logic [15:0]                   out_start_column,
  output logic [7:0]                    out_span_length,
  output logic                          out_last
);

  localparam int ACC_W = 8 * MAX_PIXEL_BYTES;

  logic [2:0]       bpp_r;
  logic [15:0]      width_r;
  logic [7:0]       pl_r;
  logic [1:0]       bi_r;
  logic [ACC_W-1:0] accum_r;
  logic [15:0]      col_r;
  logic [15:0]      line_r;
  logic [7:0]       rem_r;
  logic [31:0]      hold_r;
  logic             out_valid_r;
  logic [31:0]      out_color_r;
  logic [15:0]      out_line_r;
  logic [15:0]      out_col_r;
  logic [7:0]       out_len_r;
  logic             out_last_r;

  logic [2:0]       eff_bpp;
  logic [15:0]      eff_width;
  logic [1:0]       bi_inc;
  logic [ACC_W-1:0] merged;
  logic [31:0]      color_now;
  logic [31:0]      span_color;
  logic [7:0]       count;
  logic             wrap;
  logic [15:0]      col0;
  logic [15:0]      line0;
  logic [15:0]      room;
  logic [7:0]       len;
  logic [7:0]       rem_nxt;
  logic [15:0]      col_nxt;
  logic [7:0]       hdr_count;
  logic             slot_free;

  // Effective configuration.
  always_comb begin
    eff_bpp = bpp_r;
    if (bpp_r == 3'd0) begin
      eff_bpp = 3'd1;
    end else if (bpp_r > 3'(MAX_PIXEL_BYTES)) begin
      eff_bpp = 3'(MAX_PIXEL_BYTES);
    end
    eff_width = (width_r < trd_pkg::MIN_WIDTH) ? trd_pkg::MIN_WIDTH : width_r;
  end

  // Pixel assembly: the new byte lands in the lane picked by the byte index.
  for (genvar k = 0; k < MAX_PIXEL_BYTES; k++) begin : g_lane
    assign merged[8*k +: 8] = (bi_r == 2'(k)) ? in_data_byte : accum_r[8*k +: 8];
  end

  assign bi_inc    = bi_r + 2'd1;
  assign color_now = 32'(merged);
  assign hdr_count = in_data_byte[7] ? (in_data_byte - trd_pkg::RUN_BIAS)
                                     : (in_data_byte + 8'd1);

  // Span split: wrap first if the column is at or beyond the line end,
  // then take as many pixels as fit on the line.
  always_comb begin
    if (cmd.use_rem) begin
      count = rem_r;
    end else if (cmd.is_run) begin
      count = pl_r;
    end else begin
      count = 8'd1;
    end
    span_color = cmd.use_rem ? hold_r : color_now;
    wrap  = (col_r >= eff_width);
    col0  = wrap ? 16'd0 : col_r;
    line0 = (wrap && (line_r != trd_pkg::LINE_MAX)) ? (line_r + 16'd1) : line_r;
    room  = eff_width - col0;
    len   = (room < {8'd0, count}) ? room[7:0] : count;
    rem_nxt = count - len;
    col_nxt = col0 + {8'd0, len};
  end

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    stat.hdr_literal = !in_data_byte[7];
    stat.pix_done    = (bi_inc == 2'd0) || ({1'b0, bi_inc} >= eff_bpp);
    stat.span_done   = (rem_nxt == 8'd0);
    stat.lit_end     = (pl_r == 8'd1);
    stat.slot_free   = slot_free;
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r       <= trd_pkg::BPP_RESET;
      width_r     <= trd_pkg::WIDTH_RESET;
      pl_r        <= '0;
      bi_r        <= '0;
      accum_r     <= '0;
      col_r       <= '0;
      line_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          trd_pkg::CFG_BYTES_PER_PIXEL: bpp_r   <= cfg_data[2:0];
          trd_pkg::CFG_IMAGE_WIDTH:     width_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.hdr_load) begin
        pl_r    <= hdr_count;
        bi_r    <= '0;
        accum_r <= '0;
      end else if (cmd.pix_byte) begin
        if (stat.pix_done) begin
          bi_r    <= '0;
          accum_r <= '0;
        end else begin
          bi_r    <= bi_inc;
          accum_r <= merged;
        end
      end
      if (cmd.lit_dec) begin
        pl_r <= pl_r - 8'd1;
      end
      if (cmd.emit) begin
        col_r  <= col_nxt;
        line_r <= line0;
        rem_r  <= rem_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.hold_color) begin
      hold_r <= color_now;
    end
    if (cmd.emit) begin
      out_color_r <= span_color;
      out_line_r  <= line0;
      out_col_r   <= col0;
      out_len_r   <= len;
      out_last_r  <= stat.span_done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_color        = out_color_r;
  assign out_line         = out_line_r;
  assign out_start_column = out_col_r;
  assign out_span_length  = out_len_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  // A span is only loaded when the output register is free or draining.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> slot_free)
    else $error("span loaded over an undelivered span");

  // Every delivered span carries between 1 and 128 pixels.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != 8'd0) && (out_len_r <= 8'd128))
    else $error("span length out of range");

  // The byte index never points past the widest pixel.
  a_bi_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, bi_r} <= 3'(MAX_PIXEL_BYTES - 1))
    else $error("byte index beyond pixel size");
`endif

endmodule
